>>> design/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> design/dzr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dzr_pkg;

  localparam int unsigned IDX_W   = 2;
  localparam int unsigned RAW_W   = 16;
  localparam int unsigned TDZ_W   = 8;
  localparam int unsigned SDZ_W   = 15;
  localparam int unsigned MAG_W   = 16;
  localparam int unsigned SCALE_W = 15;
  localparam int unsigned DEN_W   = 15;
  localparam int unsigned Q_W     = 16;
  localparam int unsigned PROD_W  = MAG_W + SCALE_W;

  localparam logic [TDZ_W-1:0] TDZ_RESET = 8'd30;
  localparam logic [SDZ_W-1:0] SDZ_RESET = 15'd7849;
  localparam logic [TDZ_W-1:0] TRIG_FULL = 8'd255;

  localparam logic [RAW_W-1:0] OUT_MAX = 16'h7FFF;
  localparam logic [RAW_W-1:0] OUT_MIN = 16'h8000;

  typedef enum logic {
    KIND_TRIGGER = 1'b0,
    KIND_STICK   = 1'b1
  } kind_t;

  typedef enum logic {
    REG_TRIGGER_DZ = 1'b0,
    REG_STICK_DZ   = 1'b1
  } reg_idx_t;

  // per-item sideband that rides along the whole pipe
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             neg;   // result is negative
    logic             zero;  // inside dead zone
    logic             sat;   // saturate regardless of quotient
  } meta_t;

  typedef struct packed {
    meta_t              meta;
    logic [MAG_W-1:0]   mag;
    logic [SCALE_W-1:0] scale;
    logic [DEN_W-1:0]   den;
  } prep_t;

  typedef struct packed {
    meta_t             meta;
    logic [PROD_W-1:0] prod;
    logic [DEN_W-1:0]  den;
  } mul_t;

  typedef struct packed {
    meta_t          meta;
    logic [Q_W-1:0] quo;
  } quo_t;

endpackage

`default_nettype wire

>>> design/dzr_prep.sv
`timescale 1ns / 1ps
`default_nettype none

// Stage 1: dead-zone test, magnitude past the dead zone, rescale divisor.
module dzr_prep #(
  parameter int unsigned AXIS_FULL_SCALE = 32767
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [dzr_pkg::TDZ_W-1:0]   trig_dz,
  input  wire logic [dzr_pkg::SDZ_W-1:0]   stick_dz,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire dzr_pkg::kind_t              in_kind,
  input  wire logic [dzr_pkg::IDX_W-1:0]   in_idx,
  input  wire logic [dzr_pkg::RAW_W-1:0]   in_raw,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output dzr_pkg::prep_t                   out_data
);

  logic [dzr_pkg::TDZ_W-1:0] tv;
  logic                      t_zero;
  logic signed [16:0]        xs;
  logic signed [16:0]        dzs;
  logic signed [16:0]        den_s;
  logic signed [16:0]        mag_s;
  logic                      s_pos;
  logic                      s_neg;
  dzr_pkg::prep_t            nxt;

  assign tv     = in_raw[dzr_pkg::TDZ_W-1:0];
  assign t_zero = (tv <= trig_dz);
  assign xs     = $signed({in_raw[dzr_pkg::RAW_W-1], in_raw});
  assign dzs    = $signed({2'b00, stick_dz});
  assign den_s  = $signed(17'(AXIS_FULL_SCALE)) - dzs;
  assign s_pos  = (xs > dzs);
  assign s_neg  = (xs < -dzs);
  assign mag_s  = s_pos ? (xs - dzs) : (-xs - dzs);

  always_comb begin
    nxt          = '0;
    nxt.meta.idx = in_idx;
    unique case (in_kind)
      dzr_pkg::KIND_TRIGGER: begin
        nxt.meta.neg  = 1'b0;
        nxt.meta.zero = t_zero;
        nxt.meta.sat  = 1'b0;
        nxt.mag       = dzr_pkg::MAG_W'(tv - trig_dz);
        nxt.scale     = dzr_pkg::SCALE_W'(dzr_pkg::TRIG_FULL);
        nxt.den       = dzr_pkg::DEN_W'(dzr_pkg::TRIG_FULL - trig_dz);
      end
      dzr_pkg::KIND_STICK: begin
        nxt.meta.neg  = s_neg;
        nxt.meta.zero = ~s_pos & ~s_neg;
        nxt.meta.sat  = (den_s <= 17'sd0);
        nxt.mag       = mag_s[dzr_pkg::MAG_W-1:0];
        nxt.scale     = dzr_pkg::SCALE_W'(AXIS_FULL_SCALE);
        nxt.den       = den_s[dzr_pkg::DEN_W-1:0];
      end
      default: nxt = '0;
    endcase
  end

  assign in_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/dzr_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// Stage 2: magnitude times full scale.
module dzr_mul (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire dzr_pkg::prep_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output dzr_pkg::mul_t       out_data
);

  logic [dzr_pkg::PROD_W-1:0] prod;

  assign prod     = dzr_pkg::PROD_W'(in_data.mag) * dzr_pkg::PROD_W'(in_data.scale);
  assign in_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data.meta <= in_data.meta;
      out_data.prod <= prod;
      out_data.den  <= in_data.den;
    end
  end

endmodule

`default_nettype wire

>>> design/dzr_div.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Restoring divider, one quotient bit per stage. The entry stage flags
// quotients that do not fit in Q_W bits as saturated; the steps still pass them on.
module dzr_div (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire dzr_pkg::mul_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output dzr_pkg::quo_t      out_data
);

  localparam int unsigned STEPS = dzr_pkg::Q_W;
  localparam int unsigned DW    = dzr_pkg::DEN_W;
  localparam int unsigned QW    = dzr_pkg::Q_W;

  logic                  vld  [0:STEPS];
  logic                  rdy  [0:STEPS+1];
  dzr_pkg::meta_t        meta [0:STEPS];
  logic [DW-1:0]         rem  [0:STEPS];
  logic [DW-1:0]         den  [0:STEPS];
  logic [QW-1:0]         lo   [0:STEPS];
  logic [QW-1:0]         quo  [0:STEPS];

  logic                  ovf;
  dzr_pkg::meta_t        meta0;

  assign ovf = (in_data.prod >= {in_data.den, {QW{1'b0}}});

  always_comb begin
    meta0     = in_data.meta;
    meta0.sat = in_data.meta.sat | ovf;
  end

  assign rdy[STEPS+1] = out_ready;

  genvar k;
  generate
    for (k = 0; k <= STEPS; k++) begin : g_rdy
      assign rdy[k] = ~vld[k] | rdy[k+1];
    end
  endgenerate

  assign in_ready = rdy[0];

  // entry stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      meta[0] <= meta0;
      rem[0]  <= in_data.prod[dzr_pkg::PROD_W-1:QW];
      lo[0]   <= in_data.prod[QW-1:0];
      den[0]  <= in_data.den;
      quo[0]  <= '0;
    end
  end

  generate
    for (k = 1; k <= STEPS; k++) begin : g_step
      logic [DW:0] trial;
      logic [DW:0] diff;
      logic        ge;

      assign trial = {rem[k-1], lo[k-1][QW-1]};
      assign ge    = (trial >= {1'b0, den[k-1]});
      assign diff  = trial - {1'b0, den[k-1]};

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[k] && vld[k-1]) begin
          meta[k] <= meta[k-1];
          den[k]  <= den[k-1];
          rem[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
          lo[k]   <= {lo[k-1][QW-2:0], 1'b0};
          quo[k]  <= {quo[k-1][QW-2:0], ge};
        end
      end
    end
  endgenerate

  assign out_valid     = vld[STEPS];
  assign out_data.meta = meta[STEPS];
  assign out_data.quo  = quo[STEPS];

  // remainder must end below the divisor for every item actually divided
  `ASSERT_IMPLY(a_rem_lt_den, clk, rst,
    vld[STEPS] && !meta[STEPS].zero && !meta[STEPS].sat, rem[STEPS] < den[STEPS])
  // a stalled last stage keeps its item
  `ASSERT_NEXT(a_stall_hold, clk, rst,
    vld[STEPS] && !out_ready, vld[STEPS] && $stable(quo[STEPS]))
  // an accepted item lands in the entry stage
  `ASSERT_NEXT(a_entry_load, clk, rst, in_valid && in_ready, vld[0])

endmodule

`default_nettype wire

>>> design/dzr_out.sv
`timescale 1ns / 1ps
`default_nettype none

// Final stage: dead-zone zero, sign, saturation, output register.
module dzr_out (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire dzr_pkg::quo_t              in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [dzr_pkg::IDX_W-1:0]       out_idx,
  output logic [dzr_pkg::RAW_W-1:0]       out_value
);

  logic [dzr_pkg::RAW_W-1:0] val;

  always_comb begin
    priority if (in_data.meta.zero) begin
      val = '0;
    end else if (in_data.meta.sat) begin
      val = in_data.meta.neg ? dzr_pkg::OUT_MIN : dzr_pkg::OUT_MAX;
    end else if (in_data.meta.neg) begin
      val = (in_data.quo > dzr_pkg::OUT_MIN) ? dzr_pkg::OUT_MIN : (~in_data.quo + 16'd1);
    end else begin
      val = (in_data.quo > dzr_pkg::OUT_MAX) ? dzr_pkg::OUT_MAX : in_data.quo;
    end
  end

  assign in_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_idx   <= in_data.meta.idx;
      out_value <= val;
    end
  end

endmodule

`default_nettype wire

>>> design/deadzone_axis_rescale.sv
// Pipeline from input transfer to result: prep, multiply, divider entry,
//   16 one-bit divider steps, output register.
// Throughput: one sample per cycle; each stage holds its item only while the next
//   stage is full and stalled.
// Reset (rst, synchronous): pipeline empties, trigger dead zone 30, stick dead zone 7849.
`timescale 1ns / 1ps
`default_nettype none

module deadzone_axis_rescale #(
  parameter int unsigned AXIS_FULL_SCALE = 32767
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // config write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_addr,
  input  wire logic [14:0] cfg_data,
  // sample in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // [1:0] controller_index, [17:2] raw_value
  input  wire logic [0:0]  s_axis_tuser,  // [0] req_type
  // result out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata   // [1:0] controller_index_out, [17:2] scaled_value
);

  logic [dzr_pkg::TDZ_W-1:0] trig_dz;
  logic [dzr_pkg::SDZ_W-1:0] stick_dz;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trig_dz  <= dzr_pkg::TDZ_RESET;
      stick_dz <= dzr_pkg::SDZ_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (dzr_pkg::reg_idx_t'(cfg_addr))
        dzr_pkg::REG_TRIGGER_DZ: trig_dz  <= cfg_data[dzr_pkg::TDZ_W-1:0];
        dzr_pkg::REG_STICK_DZ:   stick_dz <= cfg_data[dzr_pkg::SDZ_W-1:0];
        default: ;
      endcase
    end
  end

  logic           p_valid, p_ready;
  dzr_pkg::prep_t p_data;
  logic           m_valid, m_ready;
  dzr_pkg::mul_t  m_data;
  logic           d_valid, d_ready;
  dzr_pkg::quo_t  d_data;

  logic [dzr_pkg::IDX_W-1:0] o_idx;
  logic [dzr_pkg::RAW_W-1:0] o_value;

  dzr_prep #(
    .AXIS_FULL_SCALE(AXIS_FULL_SCALE)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .trig_dz  (trig_dz),
    .stick_dz (stick_dz),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_kind  (dzr_pkg::kind_t'(s_axis_tuser[0])),
    .in_idx   (s_axis_tdata[1:0]),
    .in_raw   (s_axis_tdata[17:2]),
    .out_valid(p_valid),
    .out_ready(p_ready),
    .out_data (p_data)
  );

  dzr_mul u_mul (
    .clk      (clk),
    .rst      (rst),
    .in_valid (p_valid),
    .in_ready (p_ready),
    .in_data  (p_data),
    .out_valid(m_valid),
    .out_ready(m_ready),
    .out_data (m_data)
  );

  dzr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (m_valid),
    .in_ready (m_ready),
    .in_data  (m_data),
    .out_valid(d_valid),
    .out_ready(d_ready),
    .out_data (d_data)
  );

  dzr_out u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d_valid),
    .in_ready (d_ready),
    .in_data  (d_data),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_idx  (o_idx),
    .out_value(o_value)
  );

  assign m_axis_tdata = {6'b000000, o_value, o_idx};

endmodule

`default_nettype wire

>>> tb/deadzone_axis_rescale_chk.sv
`timescale 1ns / 1ps

module deadzone_axis_rescale_chk
  import dzr_pkg::*;
#(
  parameter int unsigned FULL_SCALE = 32767
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic        cfg_addr,
  input  wire logic [14:0] cfg_data,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,
  input  wire logic [0:0]  s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [23:0] m_axis_tdata,
  output int               mismatch_count,
  output int               results_owed
);

  localparam longint TRIG_SPAN = longint'(TRIG_FULL);
  localparam longint Q_HI      = 32767;
  localparam longint Q_LO      = -32768;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [RAW_W-1:0] value;
  } axis_result_t;

  logic [TDZ_W-1:0] trig_dz;
  logic [SDZ_W-1:0] stick_dz;
  axis_result_t     owed_q[$];

  // dead-zone removal and rescale under the current register values
  function automatic logic [RAW_W-1:0] rescaled_axis(kind_t kind, logic [RAW_W-1:0] raw);
    longint v;
    longint dz;
    longint den;
    longint num;
    longint q;
    if (kind == KIND_TRIGGER) begin
      v  = longint'(raw[7:0]);
      dz = longint'(trig_dz);
      if (v <= dz) return '0;
      q = (v - dz) * TRIG_SPAN / (TRIG_SPAN - dz);
      return q[RAW_W-1:0];
    end
    v   = longint'($signed(raw));
    dz  = longint'(stick_dz);
    den = longint'(FULL_SCALE) - dz;
    if (v > dz) begin
      num = v - dz;
    end else if (v < -dz) begin
      num = v + dz;
    end else begin
      return '0;
    end
    if (den <= 0) return (num > 0) ? OUT_MAX : OUT_MIN;
    q = num * longint'(FULL_SCALE) / den;
    if (q > Q_HI) return OUT_MAX;
    if (q < Q_LO) return OUT_MIN;
    return q[RAW_W-1:0];
  endfunction

  always @(posedge clk) begin
    axis_result_t exp_r;
    axis_result_t got_r;
    if (rst) begin
      trig_dz        = TDZ_RESET;
      stick_dz       = SDZ_RESET;
      owed_q.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (reg_idx_t'(cfg_addr) == REG_TRIGGER_DZ) begin
          trig_dz = cfg_data[TDZ_W-1:0];
        end else begin
          stick_dz = cfg_data[SDZ_W-1:0];
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        exp_r.idx   = s_axis_tdata[1:0];
        exp_r.value = rescaled_axis(kind_t'(s_axis_tuser[0]), s_axis_tdata[17:2]);
        owed_q.push_back(exp_r);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_r.idx   = m_axis_tdata[1:0];
        got_r.value = m_axis_tdata[17:2];
        if (owed_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result transfer: index %0d, value %0d",
                   $time, got_r.idx, $signed(got_r.value));
        end else begin
          exp_r = owed_q.pop_front();
          if (got_r.idx !== exp_r.idx) begin
            mismatch_count++;
            $display("%0t: controller index mismatch: expected %0d, got %0d",
                     $time, exp_r.idx, got_r.idx);
          end
          if (got_r.value !== exp_r.value) begin
            mismatch_count++;
            $display("%0t: scaled value mismatch: expected %0d, got %0d",
                     $time, $signed(exp_r.value), $signed(got_r.value));
          end
        end
      end
    end
    results_owed <= owed_q.size();
  end

endmodule

>>> tb/deadzone_axis_rescale_tb.sv
`timescale 1ns / 1ps

module deadzone_axis_rescale_tb;
  import dzr_pkg::*;

  localparam int unsigned FULL_SCALE   = 32767;
  localparam int          N_PHASES     = 7;
  localparam int          PHASE_ITEMS  = 76;
  localparam int          N_DIRECTED   = 18;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_addr;
  logic [14:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [1:0] controller_index, [17:2] raw_value
  logic [0:0]  s_axis_tuser;   // [0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [1:0] controller_index_out, [17:2] scaled_value

  int               mismatch_count;
  int               results_owed;
  logic             src_idle_en;
  logic             sink_stall_en;
  int               stall_left;
  logic [TDZ_W-1:0] cur_tdz;
  logic [SDZ_W-1:0] cur_sdz;

  deadzone_axis_rescale #(
    .AXIS_FULL_SCALE(FULL_SCALE)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  deadzone_axis_rescale_chk #(
    .FULL_SCALE(FULL_SCALE)
  ) u_chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatch_count(mismatch_count),
    .results_owed  (results_owed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // raw sample biased toward the dead-zone edges of the current setting
  function automatic logic [RAW_W-1:0] pick_raw(kind_t kind);
    int               sel;
    logic [RAW_W-1:0] r;
    logic [RAW_W-1:0] dz;
    sel = $urandom_range(0, 9);
    r   = 16'($urandom);
    if (kind == KIND_TRIGGER) begin
      dz = {8'h00, cur_tdz};
      case (sel)
        0: r = dz;
        1: r = dz + 16'd1;
        2: r = dz - 16'd1;
        3: r = 16'h00FF;
        4: r = 16'h0000;
        5, 6, 7: r = {8'h00, r[7:0]};
        default: ;  // upper byte is ignored by a trigger
      endcase
    end else begin
      dz = {1'b0, cur_sdz};
      case (sel)
        0: r = dz;
        1: r = dz + 16'd1;
        2: r = -dz;
        3: r = -dz - 16'd1;
        4: r = 16'h7FFF;
        5: r = 16'h8000;
        6: r = dz + 16'($urandom_range(0, 255));
        default: ;
      endcase
    end
    return r;
  endfunction

  // sink side: random stalls on the result channel
  always @(posedge clk) begin
    if (rst) begin
      stall_left    <= 0;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_stall_en && $urandom_range(0, 3) == 0) begin
      stall_left    <= pick_gap() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // returns at the edge of the transfer; valid stays up for a back-to-back item
  task automatic send_sample(kind_t kind, logic [IDX_W-1:0] idx, logic [RAW_W-1:0] raw);
    int gap;
    gap = (src_idle_en && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, raw, idx};
    s_axis_tuser  <= kind;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic write_reg(reg_idx_t which, logic [14:0] data);
    cfg_valid <= 1'b1;
    cfg_addr  <= which;
    cfg_data  <= data;
    if (which == REG_TRIGGER_DZ) begin
      cur_tdz = data[TDZ_W-1:0];
    end else begin
      cur_sdz = data[SDZ_W-1:0];
    end
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  initial begin
    logic [16:0]  directed_list [N_DIRECTED];
    logic [14:0]  tdz_w;
    logic [14:0]  sdz_w;
    kind_t        kind;
    directed_list = '{
      {KIND_TRIGGER, 16'd0},    {KIND_TRIGGER, 16'd30},   {KIND_TRIGGER, 16'd31},
      {KIND_TRIGGER, 16'd255},  {KIND_TRIGGER, 16'd128},  {KIND_TRIGGER, 16'hFFFF},
      {KIND_TRIGGER, 16'h1F00}, {KIND_TRIGGER, 16'h801F}, {KIND_STICK, 16'd0},
      {KIND_STICK, 16'd7849},   {KIND_STICK, 16'(-7849)}, {KIND_STICK, 16'd7850},
      {KIND_STICK, 16'(-7850)}, {KIND_STICK, 16'h7FFF},   {KIND_STICK, 16'h8000},
      {KIND_STICK, 16'h8001},   {KIND_STICK, 16'h5555},   {KIND_STICK, 16'hAAAA}
    };
    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_addr      <= REG_TRIGGER_DZ;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= KIND_TRIGGER;
    sink_stall_en <= 1'b1;
    src_idle_en    = 1'b1;
    cur_tdz        = TDZ_RESET;
    cur_sdz        = SDZ_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // edges and odd encodings under the reset dead zones
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_sample(kind_t'(directed_list[i][16]), 2'(i), directed_list[i][15:0]);
    end
    s_axis_tvalid <= 1'b0;

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: begin tdz_w = 15'd0;      sdz_w = 15'd0;     end
        1: begin tdz_w = 15'd254;    sdz_w = 15'd32766; end
        2: begin tdz_w = 15'h7FFF;   sdz_w = 15'd32767; end  // trigger dz reads 255
        3: begin tdz_w = 15'd1;      sdz_w = 15'd1;     end
        4: begin tdz_w = 15'h7F80;   sdz_w = 15'd16384; end
        default: begin
          tdz_w = 15'($urandom);
          sdz_w = 15'($urandom);
        end
      endcase
      write_reg(REG_TRIGGER_DZ, tdz_w);
      write_reg(REG_STICK_DZ, sdz_w);
      cfg_valid     <= 1'b0;
      src_idle_en    = (ph % 4 == 0) || (ph % 4 == 2);
      sink_stall_en <= (ph % 4 == 0) || (ph % 4 == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        kind = kind_t'($urandom_range(0, 1));
        send_sample(kind, 2'($urandom), pick_raw(kind));
      end
      s_axis_tvalid <= 1'b0;
    end

    wait_drained();
    repeat (30) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
